/* src/txn_page_free_list_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the transactional page free list.
// Shared helpers that keep the checker assertions short and uniform.
// ----------------------------------------------------------------------------
`ifndef TXN_PAGE_FREE_LIST_UNIT_DEFINES_SVH
`define TXN_PAGE_FREE_LIST_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TFL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("free list check failed");

// Next-cycle implication, checked outside reset.
`define TFL_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("free list check failed");

`endif

/* src/tfl_pkg.sv */
// ----------------------------------------------------------------------------
// tfl_pkg
// Widths, codes and the result type of the transactional page free list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tfl_pkg;

    localparam int NUM_PAGES_DEF = 1024;

    localparam int CMD_W  = 3;
    localparam int PAGE_W = 10;
    localparam int TXN_W  = 32;
    localparam int STAT_W = 2;
    localparam int PS_W   = 2;

    localparam logic [CMD_W-1:0] CMD_ALLOC    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FREE     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ROLLBACK = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd4;

    localparam logic [PS_W-1:0] PS_USED = 2'd0;
    localparam logic [PS_W-1:0] PS_FREE = 2'd1;
    localparam logic [PS_W-1:0] PS_PEND = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_RESERVED = 2'd1;
    localparam logic [STAT_W-1:0] ST_FREED    = 2'd2;
    localparam logic [STAT_W-1:0] ST_NORUN    = 2'd3;

    typedef struct packed {
        logic [PAGE_W-1:0] first_page;
        logic              is_free;
        logic [STAT_W-1:0] status;
    } tfl_result_t;

endpackage

/* src/tfl_page_store.sv */
// ----------------------------------------------------------------------------
// tfl_page_store
// Page status and pending tag memories, one read and one write port each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfl_page_store
    import tfl_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF,
    parameter int AW        = $clog2(NUM_PAGES)
)
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [PS_W-1:0]  rd_status,
    output logic [TXN_W-1:0] rd_tag,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [PS_W-1:0]  wr_status,
    input  logic             wr_tag_en,
    input  logic [TXN_W-1:0] wr_tag
);

    logic [PS_W-1:0]  status_mem [NUM_PAGES];
    logic [TXN_W-1:0] tag_mem    [NUM_PAGES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            status_mem[wr_addr] <= wr_status;
        end
        if (rd_en)
        begin
            rd_status <= status_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_tag_en)
        begin
            tag_mem[wr_addr] <= wr_tag;
        end
        if (rd_en)
        begin
            rd_tag <= tag_mem[rd_addr];
        end
    end

endmodule

/* src/tfl_ctrl.sv */
// ----------------------------------------------------------------------------
// tfl_ctrl
// Command sequencer: scans, checks and rewrites the page memories.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfl_ctrl
    import tfl_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF,
    parameter int AW        = $clog2(NUM_PAGES)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [PAGE_W-1:0] page_id,
    input  logic [PAGE_W-1:0] run_length,
    input  logic [TXN_W-1:0]  txn_id,
    output logic              res_valid,
    input  logic              res_take,
    output tfl_result_t       res,
    output logic              rd_en,
    output logic [AW-1:0]     rd_addr,
    input  logic [PS_W-1:0]   rd_status,
    input  logic [TXN_W-1:0]  rd_tag,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [PS_W-1:0]   wr_status,
    output logic              wr_tag_en,
    output logic [TXN_W-1:0]  wr_tag
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_ASCAN  = 4'd2;
    localparam logic [3:0] S_AFILL  = 4'd3;
    localparam logic [3:0] S_FCHK   = 4'd4;
    localparam logic [3:0] S_FWRITE = 4'd5;
    localparam logic [3:0] S_SWEEP  = 4'd6;
    localparam logic [3:0] S_QRY    = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_PAGES - 1);

    logic [3:0]        state_reg, state_next;
    logic [AW-1:0]     cur_reg, cur_next;
    logic [AW-1:0]     wptr_reg, wptr_next;
    logic [AW-1:0]     last_reg, last_next;
    logic [AW-1:0]     start_reg, start_next;
    logic [PAGE_W-1:0] run_reg, run_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [PAGE_W-1:0] len_reg, len_next;
    logic [TXN_W-1:0]  txn_reg, txn_next;
    tfl_result_t       res_reg, res_next;

    logic [PAGE_W:0]   free_last;
    logic              hit;

    assign free_last = {1'b0, page_id} + {1'b0, run_length};
    assign res       = res_reg;
    assign res_valid = (state_reg == S_DONE);
    assign in_stall  = (state_reg != S_IDLE);
    assign wr_tag    = txn_reg;

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        wptr_next  = wptr_reg;
        last_next  = last_reg;
        start_next = start_reg;
        run_next   = run_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        txn_next   = txn_reg;
        res_next   = res_reg;
        rd_en      = 1'b0;
        rd_addr    = cur_reg;
        wr_en      = 1'b0;
        wr_addr    = wptr_reg;
        wr_status  = PS_USED;
        wr_tag_en  = 1'b0;
        hit        = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = cur_reg;
                if (cur_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cur_next = cur_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = cmd;
                    len_next = run_length;
                    txn_next = txn_id;
                    res_next = '0;
                    run_next = '0;
                    unique case (cmd)
                        CMD_ALLOC:
                        begin
                            if (run_length == '0)
                            begin
                                res_next.status = ST_NORUN;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                cur_next   = '0;
                                state_next = S_ASCAN;
                            end
                        end
                        CMD_FREE:
                        begin
                            if (page_id <= PAGE_W'(1))
                            begin
                                res_next.status = ST_RESERVED;
                                state_next      = S_DONE;
                            end
                            else if (32'(free_last) >= 32'(NUM_PAGES))
                            begin
                                res_next.status = ST_NORUN;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(page_id);
                                cur_next   = AW'(page_id);
                                wptr_next  = AW'(page_id);
                                last_next  = AW'(free_last);
                                state_next = S_FCHK;
                            end
                        end
                        CMD_RELEASE, CMD_ROLLBACK:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            cur_next   = '0;
                            state_next = S_SWEEP;
                        end
                        CMD_QUERY:
                        begin
                            if (32'(page_id) >= 32'(NUM_PAGES))
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(page_id);
                                state_next = S_QRY;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ASCAN:
            begin
                if (rd_status == PS_FREE &&
                    ({1'b0, run_reg} + 1'b1) == {1'b0, len_reg})
                begin
                    start_next = cur_reg - AW'(len_reg) + 1'b1;
                    wptr_next  = cur_reg - AW'(len_reg) + 1'b1;
                    state_next = S_AFILL;
                end
                else
                begin
                    run_next = (rd_status == PS_FREE) ? run_reg + 1'b1 : '0;
                    if (cur_reg == LAST_ADDR)
                    begin
                        res_next.status = ST_NORUN;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = cur_reg + 1'b1;
                        cur_next = cur_reg + 1'b1;
                    end
                end
            end
            S_AFILL:
            begin
                wr_en = 1'b1;
                if (wptr_reg == cur_reg)
                begin
                    res_next.first_page = PAGE_W'(start_reg);
                    state_next          = S_DONE;
                end
                else
                begin
                    wptr_next = wptr_reg + 1'b1;
                end
            end
            S_FCHK:
            begin
                if (rd_status == PS_FREE || rd_status == PS_PEND)
                begin
                    res_next.status = ST_FREED;
                    state_next      = S_DONE;
                end
                else if (cur_reg == last_reg)
                begin
                    state_next = S_FWRITE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = cur_reg + 1'b1;
                    cur_next = cur_reg + 1'b1;
                end
            end
            S_FWRITE:
            begin
                wr_en     = 1'b1;
                wr_tag_en = 1'b1;
                wr_status = PS_PEND;
                if (wptr_reg == last_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    wptr_next = wptr_reg + 1'b1;
                end
            end
            S_SWEEP:
            begin
                hit = (rd_status == PS_PEND) &&
                      ((cmd_reg == CMD_RELEASE) ? (rd_tag <= txn_reg) : (rd_tag == txn_reg));
                wr_en     = hit;
                wr_addr   = cur_reg;
                wr_status = (cmd_reg == CMD_RELEASE) ? PS_FREE : PS_USED;
                if (cur_reg == LAST_ADDR)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = cur_reg + 1'b1;
                    cur_next = cur_reg + 1'b1;
                end
            end
            S_QRY:
            begin
                res_next.is_free = (rd_status == PS_FREE) || (rd_status == PS_PEND);
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cur_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wptr_reg  <= wptr_next;
        last_reg  <= last_next;
        start_reg <= start_next;
        run_reg   <= run_next;
        cmd_reg   <= cmd_next;
        len_reg   <= len_next;
        txn_reg   <= txn_next;
        res_reg   <= res_next;
    end

endmodule

/* src/txn_page_free_list_unit.sv */
// Throughput: one beat at a time; the memory scan of up to NUM_PAGES entries
// through the single read port sets the rate of allocate, release, rollback.
// After reset a clearing pass over all NUM_PAGES entries marks all pages in use;
// no input beat is taken until it ends.
// ----------------------------------------------------------------------------
// txn_page_free_list_unit
// Transactional page free list with allocate, free, release and rollback.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module txn_page_free_list_unit
    import tfl_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [PAGE_W-1:0] page_id,
    input  logic [PAGE_W-1:0] run_length,
    input  logic [TXN_W-1:0]  txn_id,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [PAGE_W-1:0] first_page,
    output logic              is_free,
    output logic [STAT_W-1:0] status
);

    localparam int AW = $clog2(NUM_PAGES);

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [PS_W-1:0]   rd_status;
    logic [TXN_W-1:0]  rd_tag;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [PS_W-1:0]   wr_status;
    logic              wr_tag_en;
    logic [TXN_W-1:0]  wr_tag;
    logic              res_valid;
    logic              res_take;
    tfl_result_t       res;
    logic              out_valid_reg;
    tfl_result_t       out_reg;

    tfl_ctrl #(.NUM_PAGES(NUM_PAGES), .AW(AW)) u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .page_id    (page_id),
        .run_length (run_length),
        .txn_id     (txn_id),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_status  (rd_status),
        .rd_tag     (rd_tag),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_status  (wr_status),
        .wr_tag_en  (wr_tag_en),
        .wr_tag     (wr_tag)
    );

    tfl_page_store #(.NUM_PAGES(NUM_PAGES), .AW(AW)) u_store
    (
        .clk       (clk),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_status (rd_status),
        .rd_tag    (rd_tag),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_status (wr_status),
        .wr_tag_en (wr_tag_en),
        .wr_tag    (wr_tag)
    );

    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign first_page = out_reg.first_page;
    assign is_free    = out_reg.is_free;
    assign status     = out_reg.status;

endmodule

/* src/tfl_checker.sv */
// ----------------------------------------------------------------------------
// tfl_checker
// Port-level checks of the free list, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "txn_page_free_list_unit_defines.svh"

module tfl_checker
    import tfl_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [PAGE_W-1:0] first_page,
    input logic              is_free,
    input logic [STAT_W-1:0] status
);

    `TFL_ASSERT_NXT(a_busy_after_beat, in_valid && !in_stall, in_stall)
    `TFL_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
    `TFL_ASSERT_NXT(a_out_stable, out_valid && out_stall,
        $stable(first_page) && $stable(is_free) && $stable(status))
    `TFL_ASSERT_IMP(a_page_ok, out_valid && first_page != '0, status == ST_OK && !is_free)
    `TFL_ASSERT_IMP(a_free_ok, out_valid && is_free, status == ST_OK)

endmodule

bind txn_page_free_list_unit tfl_checker u_tfl_checker (.*);

/* verif/txn_page_free_list_unit_tb.sv */
// ----------------------------------------------------------------------------
// txn_page_free_list_unit_tb
// Checks allocate, free, release, rollback, query and unknown commands.
// A page table model inside the testbench predicts each result beat, and
// the checker compares every result beat with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module txn_page_free_list_unit_tb;
    import tfl_pkg::*;

    localparam int PAGES = NUM_PAGES_DEF;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [CMD_W-1:0]  cmd;
    logic [PAGE_W-1:0] page_id;
    logic [PAGE_W-1:0] run_length;
    logic [TXN_W-1:0]  txn_id;
    logic              out_valid;
    logic              out_stall;
    logic [PAGE_W-1:0] first_page;
    logic              is_free;
    logic [STAT_W-1:0] status;

    logic [PS_W-1:0]  page_state [PAGES];
    logic [TXN_W-1:0] page_tag [PAGES];
    tfl_result_t      pending_results [$];
    logic [TXN_W-1:0] txn_pool [8];
    int               errors = 0;
    int               send_idle_pct;
    int               recv_idle_pct;

    txn_page_free_list_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .page_id    (page_id),
        .run_length (run_length),
        .txn_id     (txn_id),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .first_page (first_page),
        .is_free    (is_free),
        .status     (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic tfl_result_t apply_to_table(logic [CMD_W-1:0] c, logic [PAGE_W-1:0] p,
                                                  logic [PAGE_W-1:0] n, logic [TXN_W-1:0] t);
        tfl_result_t r;
        int          run;
        int          last;
        bit          busy;
        r = '0;
        r.status = ST_OK;
        case (c)
            CMD_ALLOC:
            begin
                r.status = ST_NORUN;
                run = 0;
                if (n != 0)
                begin
                    for (int i = 0; i < PAGES; i++)
                    begin
                        if (page_state[i] == PS_FREE)
                        begin
                            run++;
                            if (run == n)
                            begin
                                for (int j = i + 1 - n; j <= i; j++)
                                    page_state[j] = PS_USED;
                                r.first_page = PAGE_W'(i + 1 - n);
                                r.status = ST_OK;
                                break;
                            end
                        end
                        else
                            run = 0;
                    end
                end
            end
            CMD_FREE:
            begin
                last = int'(p) + int'(n);
                busy = 1'b0;
                if (p <= 1)
                    r.status = ST_RESERVED;
                else if (last >= PAGES)
                    r.status = ST_NORUN;
                else
                begin
                    for (int i = int'(p); i <= last; i++)
                        if (page_state[i] == PS_FREE || page_state[i] == PS_PEND)
                            busy = 1'b1;
                    if (busy)
                        r.status = ST_FREED;
                    else
                        for (int i = int'(p); i <= last; i++)
                        begin
                            page_state[i] = PS_PEND;
                            page_tag[i] = t;
                        end
                end
            end
            CMD_RELEASE:
                for (int i = 0; i < PAGES; i++)
                    if (page_state[i] == PS_PEND && page_tag[i] <= t)
                        page_state[i] = PS_FREE;
            CMD_ROLLBACK:
                for (int i = 0; i < PAGES; i++)
                    if (page_state[i] == PS_PEND && page_tag[i] == t)
                        page_state[i] = PS_USED;
            CMD_QUERY:
                r.is_free = (page_state[p] == PS_FREE || page_state[p] == PS_PEND);
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_beat(logic [CMD_W-1:0] c, logic [PAGE_W-1:0] p,
                             logic [PAGE_W-1:0] n, logic [TXN_W-1:0] t);
        int          gap;
        tfl_result_t pred;
        gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        page_id    <= p;
        run_length <= n;
        txn_id     <= t;
        do
            @(posedge clk);
        while (in_stall);
        pred = apply_to_table(c, p, n, t);
        pending_results.insert(pending_results.size(), pred);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no prediction waiting");
                errors++;
            end
            else
            begin
                tfl_result_t e;
                e = pending_results.pop_front();
                if (first_page !== e.first_page)
                begin
                    $error("first_page expected %0d actual %0d", e.first_page, first_page);
                    errors++;
                end
                if (is_free !== e.is_free)
                begin
                    $error("is_free expected %0d actual %0d", e.is_free, is_free);
                    errors++;
                end
                if (status !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, status);
                    errors++;
                end
            end
        end
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    task automatic test_reset_state();
        send_beat(CMD_QUERY, 10'd0, 10'd0, 32'd0);
        send_beat(CMD_QUERY, 10'd1023, 10'd1023, 32'hFFFF_FFFF);
        send_beat(CMD_ALLOC, 10'd0, 10'd1, 32'd0);
        send_beat(CMD_ALLOC, 10'd0, 10'd0, 32'd0);
    endtask

    task automatic test_free_errors();
        send_beat(CMD_FREE, 10'd0, 10'd0, 32'd1);
        send_beat(CMD_FREE, 10'd1, 10'd3, 32'd1);
        send_beat(CMD_FREE, 10'd1023, 10'd1, 32'd1);
        send_beat(CMD_FREE, 10'd2, 10'd1023, 32'd1);
    endtask

    task automatic test_free_release_alloc();
        send_beat(CMD_FREE, 10'd2, 10'd7, 32'd5);
        send_beat(CMD_QUERY, 10'd9, 10'd0, 32'd0);
        send_beat(CMD_FREE, 10'd9, 10'd0, 32'd5);
        send_beat(CMD_ALLOC, 10'd0, 10'd3, 32'd0);
        send_beat(CMD_RELEASE, 10'd0, 10'd0, 32'd4);
        send_beat(CMD_RELEASE, 10'd0, 10'd0, 32'd5);
        send_beat(CMD_ALLOC, 10'd0, 10'd3, 32'd0);
        send_beat(CMD_ALLOC, 10'd0, 10'd1023, 32'd0);
        send_beat(CMD_FREE, 10'd1023, 10'd0, 32'd0);
        send_beat(CMD_RELEASE, 10'd0, 10'd0, 32'd0);
        send_beat(CMD_QUERY, 10'd1023, 10'd0, 32'd0);
    endtask

    task automatic test_rollback();
        send_beat(CMD_FREE, 10'd100, 10'd3, 32'hFFFF_FFFF);
        send_beat(CMD_ROLLBACK, 10'd0, 10'd0, 32'd7);
        send_beat(CMD_QUERY, 10'd103, 10'd0, 32'd0);
        send_beat(CMD_ROLLBACK, 10'd0, 10'd0, 32'hFFFF_FFFF);
        send_beat(CMD_QUERY, 10'd100, 10'd0, 32'd0);
    endtask

    task automatic test_unknown_cmds();
        send_beat(3'd5, 10'd1023, 10'd1023, 32'hFFFF_FFFF);
        send_beat(3'd6, 10'd0, 10'd0, 32'd0);
        send_beat(3'd7, 10'd512, 10'd5, 32'hA5A5_5A5A);
    endtask

    task automatic test_random_traffic(int beats);
        int               r;
        logic [PAGE_W-1:0] p;
        logic [PAGE_W-1:0] n;
        logic [TXN_W-1:0] t;
        for (int k = 0; k < beats; k++)
        begin
            if ($urandom_range(0, 19) == 0)
                txn_pool[$urandom_range(0, 7)] = $urandom();
            r = $urandom_range(0, 99);
            p = PAGE_W'($urandom());
            n = PAGE_W'($urandom());
            t = ($urandom_range(0, 9) == 0) ? $urandom() : txn_pool[$urandom_range(0, 7)];
            if (r < 32)
            begin
                if ($urandom_range(0, 19) != 0)
                    p = PAGE_W'($urandom_range(2, PAGES - 1));
                if ($urandom_range(0, 29) != 0)
                    n = PAGE_W'($urandom_range(0, 15));
                send_beat(CMD_FREE, p, n, t);
            end
            else if (r < 47)
                send_beat(CMD_RELEASE, p, n, t);
            else if (r < 55)
                send_beat(CMD_ROLLBACK, p, n, t);
            else if (r < 75)
            begin
                if ($urandom_range(0, 19) != 0)
                    n = PAGE_W'($urandom_range(0, 16));
                send_beat(CMD_ALLOC, p, n, t);
            end
            else if (r < 97)
                send_beat(CMD_QUERY, p, n, t);
            else
                send_beat(CMD_W'($urandom_range(5, 7)), p, n, t);
        end
    endtask

    initial
    begin
        send_idle_pct = 6;
        recv_idle_pct = 64;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        cmd           = '0;
        page_id       = '0;
        run_length    = '0;
        txn_id        = '0;
        for (int i = 0; i < PAGES; i++)
        begin
            page_state[i] = PS_USED;
            page_tag[i]   = '0;
        end
        for (int i = 0; i < 8; i++)
            txn_pool[i] = $urandom();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_free_errors();
        test_free_release_alloc();
        test_rollback();
        test_unknown_cmds();
        test_random_traffic(185);
        send_idle_pct = 64;
        recv_idle_pct = 6;
        test_random_traffic(185);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(185);
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
